[hw/rtl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, derived widths and the command bundle shared by the cache modules.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;

   // Width of an entry index and of a recency rank.
   localparam int IDX_BITS   = $clog2(ENTRIES);
   // Width of the fill count, which must hold ENTRIES itself.
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);

   // Capacity register.
   localparam int          CAP_BITS  = 5;
   localparam int unsigned CAP_RESET = 10;
   localparam int CAP_CMP_BITS = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_GET    = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_MISS = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request fields
      logic lookup;  // register the match, victim and free-slot results
      logic commit;  // update the table and load the response register
   } lkvc_cmd_type;

endpackage

[hw/rtl/lkvc_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one cache access: mode, key and value.
// ----------------------------------------------------------------------------
interface lkvc_req_if
   import lkvc_pkg::*;
   ();

   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink   (input valid, input mode, input key, input value, output ready);

endinterface

[hw/rtl/lkvc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the outcome of one cache access.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if
   import lkvc_pkg::*;
   ();

   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [VALUE_BITS-1:0] read_value;
   logic                  status;
   logic                  evicted;
   logic [KEY_BITS-1:0]   evicted_key;
   logic [COUNT_BITS-1:0] occupancy;

   modport source (output valid, output hit, output read_value, output status,
                   output evicted, output evicted_key, output occupancy, input ready);
   modport sink   (input valid, input hit, input read_value, input status,
                   input evicted, input evicted_key, input occupancy, output ready);

endinterface

[hw/rtl/lkvc_ctrl.sv]
// ----------------------------------------------------------------------------
// Cache controller
// Sequences each access through match and commit and owns the handshakes.
// ----------------------------------------------------------------------------
module lkvc_ctrl
   import lkvc_pkg::*;
   (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lkvc_cmd_type cmd
   );

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MATCH  = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit_ok;
   logic      load;

   // A commit may proceed once the response register is empty or being drained.
   assign commit_ok = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);
   // The next request can enter in the same cycle the current one commits.
   assign req_ready = (state_ff == ST_IDLE) || commit_ok;
   assign load      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_ok) state_in = load ? ST_MATCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (commit_ok) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = load;
   assign cmd.lookup = (state_ff == ST_MATCH);
   assign cmd.commit = commit_ok;

endmodule

[hw/rtl/lkvc_dp.sv]
// ----------------------------------------------------------------------------
// Cache datapath
// Entry table with parallel key match, recency ranks and the response register.
// ----------------------------------------------------------------------------
module lkvc_dp
   import lkvc_pkg::*;
   (
   input  logic                  clock,
   input  logic                  reset,
   input  lkvc_cmd_type          cmd,
   input  logic                  req_mode,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  csr_wr_en,
   input  logic [CAP_BITS-1:0]   csr_wr_data,
   output logic                  rsp_hit,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic                  rsp_status,
   output logic                  rsp_evicted,
   output logic [KEY_BITS-1:0]   rsp_evicted_key,
   output logic [COUNT_BITS-1:0] rsp_occupancy
   );

   // Entry table.
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] val_ff   [ENTRIES];
   logic [IDX_BITS-1:0]   rank_ff  [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [CAP_BITS-1:0]   cap_ff;

   // Captured request.
   logic                  mode_ff;
   logic [KEY_BITS-1:0]   rkey_ff;
   logic [VALUE_BITS-1:0] rval_ff;

   // Lookup results.
   logic                  hit_in,      hit_ff;
   logic [IDX_BITS-1:0]   hit_idx_in,  hit_idx_ff;
   logic [IDX_BITS-1:0]   lru_idx_in,  lru_idx_ff;
   logic [IDX_BITS-1:0]   free_idx_in, free_idx_ff;
   logic                  full_in,     full_ff;

   // Response register.
   logic                  o_hit_ff;
   logic [VALUE_BITS-1:0] o_rd_ff;
   logic                  o_status_ff;
   logic                  o_ev_ff;
   logic [KEY_BITS-1:0]   o_evkey_ff;
   logic [COUNT_BITS-1:0] o_occ_ff;

   logic [CAP_CMP_BITS-1:0] cap_ext;
   logic [COUNT_BITS-1:0]   eff_cap;
   logic [COUNT_BITS-1:0]   count_m1;

   // Clamp the capacity register into 1 .. ENTRIES.
   always_comb begin
      cap_ext = CAP_CMP_BITS'(cap_ff);
      if (cap_ff == '0) eff_cap = COUNT_BITS'(1);
      else if (cap_ext > CAP_CMP_BITS'(ENTRIES)) eff_cap = COUNT_BITS'(ENTRIES);
      else eff_cap = COUNT_BITS'(cap_ext);
   end

   assign count_m1 = count_ff - COUNT_BITS'(1);

   // Lookup: lowest matching valid slot, the slot holding the oldest rank and
   // the lowest free slot. Valid ranks are distinct and run 0 .. count-1.
   always_comb begin
      hit_in      = 1'b0;
      hit_idx_in  = '0;
      lru_idx_in  = '0;
      free_idx_in = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (key_ff[i] == rkey_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = IDX_BITS'(i);
         end
         if (valid_ff[i] && (COUNT_BITS'(rank_ff[i]) == count_m1)) begin
            lru_idx_in = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            free_idx_in = IDX_BITS'(i);
         end
      end
      full_in = (count_ff >= eff_cap);
   end

   // Commit decisions. The touched slot becomes most recent and every valid
   // slot more recent than its old rank ages by one. A fresh insert uses the
   // fill count as old rank so that all valid slots age.
   logic                  is_update;
   logic                  do_touch;
   logic                  do_insert;
   logic                  do_evict;
   logic [IDX_BITS-1:0]   tgt_idx;
   logic [COUNT_BITS-1:0] tgt_rank;
   logic [VALUE_BITS-1:0] rd_value;

   always_comb begin
      is_update = (mode_ff == MODE_UPDATE);
      do_touch  = hit_ff || is_update;
      do_evict  = !hit_ff && is_update && full_ff;
      do_insert = !hit_ff && is_update && !full_ff;
      if (hit_ff) begin
         tgt_idx  = hit_idx_ff;
         tgt_rank = COUNT_BITS'(rank_ff[hit_idx_ff]);
      end else if (full_ff) begin
         tgt_idx  = lru_idx_ff;
         tgt_rank = count_m1;
      end else begin
         tgt_idx  = free_idx_ff;
         tgt_rank = count_ff;
      end
      if (is_update) rd_value = rval_ff;
      else if (hit_ff) rd_value = val_ff[hit_idx_ff];
      else rd_value = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_BITS'(CAP_RESET);
      end else begin
         if (csr_wr_en && (count_ff == '0)) cap_ff <= csr_wr_data;
         if (cmd.commit && do_insert) begin
            valid_ff[tgt_idx] <= 1'b1;
            count_ff          <= count_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         rkey_ff <= req_key;
         rval_ff <= req_value;
      end
      if (cmd.lookup) begin
         hit_ff      <= hit_in;
         hit_idx_ff  <= hit_idx_in;
         lru_idx_ff  <= lru_idx_in;
         free_idx_ff <= free_idx_in;
         full_ff     <= full_in;
      end
      if (cmd.commit) begin
         if (do_touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (IDX_BITS'(i) != tgt_idx)
                   && (COUNT_BITS'(rank_ff[i]) < tgt_rank)) begin
                  rank_ff[i] <= rank_ff[i] + IDX_BITS'(1);
               end
            end
            rank_ff[tgt_idx] <= '0;
         end
         if (is_update) val_ff[tgt_idx] <= rval_ff;
         if (!hit_ff && is_update) key_ff[tgt_idx] <= rkey_ff;
         o_hit_ff    <= hit_ff;
         o_rd_ff     <= rd_value;
         o_status_ff <= (!hit_ff && !is_update) ? STATUS_MISS : STATUS_OK;
         o_ev_ff     <= do_evict;
         o_evkey_ff  <= do_evict ? key_ff[lru_idx_ff] : '0;
         o_occ_ff    <= do_insert ? (count_ff + COUNT_BITS'(1)) : count_ff;
      end
   end

   assign rsp_hit         = o_hit_ff;
   assign rsp_read_value  = o_rd_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_evicted     = o_ev_ff;
   assign rsp_evicted_key = o_evkey_ff;
   assign rsp_occupancy   = o_occ_ff;

endmodule

[hw/rtl/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Carries
//   req_chan   in         mode, key, value
//   rsp_chan   out        hit, read_value, status, evicted, evicted_key, occupancy
//   csr_*      in         capacity write (csr_wr_en, csr_wr_data)
//
// Each access passes through a match state, which compares the key with all
// entries in parallel, and a commit state, which updates values and recency
// ranks and loads the response. A new request is taken in the cycle the
// previous one commits. A full response register stalls the commit.
// Reset is synchronous and leaves the cache empty with capacity 10.
module lru_key_value_cache
   import lkvc_pkg::*;
   (
   input  logic                clock,
   input  logic                reset,
   lkvc_req_if.sink            req_chan,
   lkvc_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  logic [CAP_BITS-1:0] csr_wr_data
   );

   lkvc_cmd_type cmd;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   lkvc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_chan.mode),
      .req_key         (req_chan.key),
      .req_value       (req_chan.value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_hit         (rsp_chan.hit),
      .rsp_read_value  (rsp_chan.read_value),
      .rsp_status      (rsp_chan.status),
      .rsp_evicted     (rsp_chan.evicted),
      .rsp_evicted_key (rsp_chan.evicted_key),
      .rsp_occupancy   (rsp_chan.occupancy)
   );

endmodule
